/* hdl/prf_pkg.sv */
// ----------------------------------------------------------------------------
// prf_pkg
// Shared types and constants of the power report frame parser.
// ----------------------------------------------------------------------------
package prf_pkg;

    // configuration register indexes
    localparam logic CFG_SYNC_BYTE  = 1'b0;
    localparam logic CFG_FIELD_MASK = 1'b1;

    // configuration reset values
    localparam logic [7:0] SYNC_RESET = 8'hAE;
    localparam logic [8:0] MASK_RESET = 9'h1FE;

    // shortest frame that is parsed (sync, length, checksum)
    localparam logic [7:0] MIN_FRAME = 8'd3;

    // collector states
    typedef enum logic [0:0] {
        C_IDLE,
        C_COLLECT
    } coll_state_t;

    // emitter states
    typedef enum logic [2:0] {
        E_IDLE,
        E_ADDR,
        E_DATA,
        E_SEND,
        E_CSUM
    } emit_state_t;

    // frame completion handed from collector to emitter
    typedef struct packed {
        logic       start;
        logic [7:0] csum;
    } frame_done_t;

endpackage

/* hdl/prf_ram.sv */
// ----------------------------------------------------------------------------
// prf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module prf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 27,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/prf_collect.sv */
// ----------------------------------------------------------------------------
// prf_collect
// Byte-level frame tracker: sync hunt, length capture, payload writes into
// the RAM with per-entry valid bits, frame completion toward the emitter.
// ----------------------------------------------------------------------------
module prf_collect #(
    parameter int FIELD_COUNT = 9,
    parameter int PB          = 3 * FIELD_COUNT,
    parameter int AW          = (PB > 1) ? $clog2(PB) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_rx_byte,
    input  logic [7:0]           sync_byte,
    input  logic                 emit_busy,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [7:0]           wr_data,
    output logic [PB-1:0]        valid_vec,
    output prf_pkg::frame_done_t frame_done
);

    localparam logic [7:0] PB8 = 8'(PB);

    prf_pkg::coll_state_t state_reg, state_next;
    logic [7:0]    pos_reg, pos_next;
    logic [7:0]    len_reg, len_next;
    logic [PB-1:0] valid_reg, valid_next;

    logic       accept;
    logic       is_len;
    logic       in_store;
    logic       frame_end;
    logic       short_len;
    logic [7:0] store_idx;

    // decode of the current position
    always_comb begin
        accept    = s_valid && s_ready;
        is_len    = (pos_reg == 8'd1);
        store_idx = pos_reg - 8'd2;
        in_store  = (pos_reg >= 8'd2) && (store_idx < PB8);
        short_len = s_rx_byte < prf_pkg::MIN_FRAME;
        frame_end = !is_len && (({1'b0, pos_reg} + 9'd1) == {1'b0, len_reg});
    end

    // next state
    always_comb begin
        state_next = state_reg;
        if (accept) begin
            case (state_reg)
                prf_pkg::C_IDLE: begin
                    if (s_rx_byte == sync_byte) begin
                        state_next = prf_pkg::C_COLLECT;
                    end
                end
                prf_pkg::C_COLLECT: begin
                    if ((is_len && short_len) || frame_end) begin
                        state_next = prf_pkg::C_IDLE;
                    end
                end
                default: state_next = prf_pkg::C_IDLE;
            endcase
        end
    end

    // outputs
    always_comb begin
        s_ready          = !emit_busy;
        wr_en            = accept && (state_reg == prf_pkg::C_COLLECT) && in_store;
        wr_addr          = store_idx[AW-1:0];
        wr_data          = s_rx_byte;
        valid_vec        = valid_reg;
        frame_done.start = accept && (state_reg == prf_pkg::C_COLLECT) && frame_end;
        frame_done.csum  = s_rx_byte;
    end

    // position, length and valid bits
    always_comb begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        valid_next = valid_reg;
        if (accept) begin
            if (state_reg == prf_pkg::C_IDLE) begin
                if (s_rx_byte == sync_byte) begin
                    pos_next   = 8'd1;
                    len_next   = 8'd0;
                    valid_next = '0;
                end
            end else begin
                pos_next = pos_reg + 8'd1;
                if (is_len) begin
                    len_next = s_rx_byte;
                    if (short_len) begin
                        pos_next = 8'd0;
                    end
                end else begin
                    if (in_store) begin
                        valid_next[store_idx[AW-1:0]] = 1'b1;
                    end
                    if (frame_end) begin
                        pos_next = 8'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= prf_pkg::C_IDLE;
            pos_reg   <= 8'd0;
            len_reg   <= 8'd0;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            valid_reg <= valid_next;
        end
    end

endmodule

/* hdl/prf_emit.sv */
// ----------------------------------------------------------------------------
// prf_emit
// Result sequencer: reads the payload RAM byte by byte, assembles each
// 24-bit field, sign-extends per mask, then sends the checksum beat.
// ----------------------------------------------------------------------------
module prf_emit #(
    parameter int FIELD_COUNT = 9,
    parameter int PB          = 3 * FIELD_COUNT,
    parameter int AW          = (PB > 1) ? $clog2(PB) : 1,
    parameter int FW          = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  prf_pkg::frame_done_t frame_done,
    input  logic [PB-1:0]        valid_vec,
    input  logic [8:0]           field_mask,
    output logic                 emit_busy,
    output logic                 rd_en,
    output logic [AW-1:0]        rd_addr,
    input  logic [7:0]           rd_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [3:0]           m_item_index,
    output logic signed [24:0]   m_item_value,
    output logic                 m_frame_last
);

    localparam logic [FW-1:0] LAST_F     = FW'(FIELD_COUNT - 1);
    localparam logic [3:0]    CSUM_INDEX = 4'(FIELD_COUNT);
    localparam logic [AW-1:0] BASE_STEP  = AW'(3);

    prf_pkg::emit_state_t state_reg, state_next;
    logic [FW-1:0] f_reg, f_next;
    logic [1:0]    b_reg, b_next;
    logic [AW-1:0] base_reg, base_next;
    logic [23:0]   word_reg, word_next;
    logic [7:0]    csum_reg, csum_next;
    logic          mv_reg, mv_next;
    logic [3:0]    idx_reg, idx_next;
    logic [24:0]   val_reg, val_next;
    logic          last_reg, last_next;

    logic          slot_free;
    logic [15:0]   mask_ext;
    logic          field_signed;

    assign slot_free    = !mv_reg || m_ready;
    assign mask_ext     = {7'd0, field_mask};
    assign field_signed = mask_ext[4'(f_reg)];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            prf_pkg::E_IDLE: begin
                if (frame_done.start) begin
                    state_next = prf_pkg::E_ADDR;
                end
            end
            prf_pkg::E_ADDR: state_next = prf_pkg::E_DATA;
            prf_pkg::E_DATA: begin
                state_next = (b_reg == 2'd2) ? prf_pkg::E_SEND : prf_pkg::E_ADDR;
            end
            prf_pkg::E_SEND: begin
                if (slot_free) begin
                    state_next = (f_reg == LAST_F) ? prf_pkg::E_CSUM : prf_pkg::E_ADDR;
                end
            end
            prf_pkg::E_CSUM: begin
                if (slot_free) begin
                    state_next = prf_pkg::E_IDLE;
                end
            end
            default: state_next = prf_pkg::E_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        emit_busy    = (state_reg != prf_pkg::E_IDLE);
        rd_en        = (state_reg == prf_pkg::E_ADDR);
        rd_addr      = base_reg + AW'(b_reg);
        m_valid      = mv_reg;
        m_item_index = idx_reg;
        m_item_value = $signed(val_reg);
        m_frame_last = last_reg;
    end

    // datapath: counters, field assembly, output register
    always_comb begin
        f_next    = f_reg;
        b_next    = b_reg;
        base_next = base_reg;
        word_next = word_reg;
        csum_next = csum_reg;
        mv_next   = mv_reg && !m_ready;
        idx_next  = idx_reg;
        val_next  = val_reg;
        last_next = last_reg;
        case (state_reg)
            prf_pkg::E_IDLE: begin
                if (frame_done.start) begin
                    csum_next = frame_done.csum;
                    f_next    = '0;
                    b_next    = 2'd0;
                    base_next = '0;
                end
            end
            prf_pkg::E_DATA: begin
                // entries not written this frame read as zero
                word_next[8*b_reg +: 8] = valid_vec[rd_addr] ? rd_data : 8'd0;
                b_next = b_reg + 2'd1;
            end
            prf_pkg::E_SEND: begin
                if (slot_free) begin
                    mv_next   = 1'b1;
                    idx_next  = 4'(f_reg);
                    val_next  = {field_signed & word_reg[23], word_reg};
                    last_next = 1'b0;
                    f_next    = f_reg + FW'(1);
                    b_next    = 2'd0;
                    base_next = base_reg + BASE_STEP;
                end
            end
            prf_pkg::E_CSUM: begin
                if (slot_free) begin
                    mv_next   = 1'b1;
                    idx_next  = CSUM_INDEX;
                    val_next  = {17'd0, csum_reg};
                    last_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= prf_pkg::E_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        f_reg    <= f_next;
        b_reg    <= b_next;
        base_reg <= base_next;
        word_reg <= word_next;
        csum_reg <= csum_next;
        idx_reg  <= idx_next;
        val_reg  <= val_next;
        last_reg <= last_next;
    end

endmodule

/* hdl/power_report_frame_parser.sv */
// Throughput: one byte per cycle while collecting; at frame end the single
// RAM read port paces the burst, one field byte read (E_ADDR, E_DATA) at a
// time, each field beat registered in E_SEND. s_ready is low during the
// burst; a new byte is taken after the checksum.
// Reset: synchronous, active low; clears control, config and the payload valid
// bits at once (no clearing pass); valid bits also clear at each frame start.
// ----------------------------------------------------------------------------
// power_report_frame_parser
// Power-meter UART report frame parser: collects frame bytes into a payload
// RAM and emits the measurement fields and the checksum.
// ----------------------------------------------------------------------------
module power_report_frame_parser #(
    parameter int FIELD_COUNT = 9
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [3:0]          m_item_index,
    output logic signed [24:0]  m_item_value,
    output logic                m_frame_last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [8:0]          cfg_data
);

    localparam int PB = 3 * FIELD_COUNT;
    localparam int AW = (PB > 1) ? $clog2(PB) : 1;

    logic [7:0] sync_reg;
    logic [8:0] mask_reg;

    logic                 emit_busy;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [7:0]           wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [7:0]           rd_data;
    logic [PB-1:0]        valid_vec;
    prf_pkg::frame_done_t frame_done;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg <= prf_pkg::SYNC_RESET;
            mask_reg <= prf_pkg::MASK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                prf_pkg::CFG_SYNC_BYTE:  sync_reg <= cfg_data[7:0];
                prf_pkg::CFG_FIELD_MASK: mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // byte collector
    prf_collect #(
        .FIELD_COUNT (FIELD_COUNT),
        .PB          (PB),
        .AW          (AW)
    ) u_collect (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .sync_byte  (sync_reg),
        .emit_busy  (emit_busy),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .valid_vec  (valid_vec),
        .frame_done (frame_done)
    );

    // payload store
    prf_ram #(
        .WIDTH (8),
        .DEPTH (PB),
        .AW    (AW)
    ) u_payload_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // result sequencer
    prf_emit #(
        .FIELD_COUNT (FIELD_COUNT),
        .PB          (PB),
        .AW          (AW)
    ) u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .frame_done   (frame_done),
        .valid_vec    (valid_vec),
        .field_mask   (mask_reg),
        .emit_busy    (emit_busy),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item_index (m_item_index),
        .m_item_value (m_item_value),
        .m_frame_last (m_frame_last)
    );

`ifndef NO_ASSERTIONS
    // no byte is taken while the burst is running
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_busy |-> !s_ready)
        else $error("byte accepted during result burst");

    // a frame completes only when the emitter is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done.start |-> !emit_busy)
        else $error("frame completed while emitter busy");

    // completing a frame starts the burst on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done.start |=> emit_busy && !s_ready)
        else $error("frame completion did not start the burst");

    // the RAM is never written while the emitter reads it
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !wr_en)
        else $error("payload RAM written during readout");
`endif

endmodule
